// ===== design/bol_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list package
// Sizes, command and status codes, and the memory request bundle that the
// list core and its entry memory share.
// ----------------------------------------------------------------------------
package bol_pkg;

    // List geometry.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Command field widths.
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // One access request to the entry memory: one write and one read port.
    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr;
    } bol_mem_req_t;

endpackage

// ===== design/bounded_ordered_list_core.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list core
// Ordered list of up to CAPACITY signed values with append, insert, pop,
// remove, read and find commands.
// ----------------------------------------------------------------------------
// The list lives in a 16-entry memory with one write and one read port and
// a registered read; the core takes one command at a time. Every command
// takes one transfer in and gives one result transfer out. Append is
// decoded, writes the value and then registers its result; a command that
// fails or carries the unused code is decoded and then registers its result.
// Insert moves each entry at or above the position up one place, pop front
// and remove move each entry above the position down one place, one entry
// per cycle through the memory ports, and find reads the list one entry per
// cycle from the front until it hits; pop back and read walk a single entry.
// A new command is taken once the previous result is in the output register,
// even if that result has not yet been transferred.
// ----------------------------------------------------------------------------
module bounded_ordered_list_core
    import bol_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_W-1:0]              operation,
    input  logic [POS_W-1:0]             position,
    input  logic signed [DATA_WIDTH-1:0] value,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] data_out,
    output logic [CNT_W-1:0]             found_position,
    output logic [CNT_W-1:0]             entry_count,
    output logic [STATUS_W-1:0]          status
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_SHDN = 6'b000100,
        S_SHUP = 6'b001000,
        S_FIND = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    // Control registers.
    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] ptr_reg,    ptr_next;
    logic [CNT_W-1:0] lim_reg,    lim_next;
    logic [CNT_W-1:0] base_reg,   base_next;
    logic             pend_reg,   pend_next;
    logic             dec_reg,    dec_next;
    logic             hit_reg,    hit_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [OP_W-1:0]        op_reg,     op_next;
    logic [POS_W-1:0]       pos_reg,    pos_next;
    logic [DATA_WIDTH-1:0]  val_reg,    val_next;
    logic [IDX_W-1:0]       paddr_reg,  paddr_next;
    logic [DATA_WIDTH-1:0]  data_reg,   data_next;
    logic [CNT_W-1:0]       found_reg,  found_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [DATA_WIDTH-1:0]  dout_reg,   dout_next;
    logic [CNT_W-1:0]       fpos_reg,   fpos_next;
    logic [CNT_W-1:0]       ecnt_reg,   ecnt_next;
    logic [STATUS_W-1:0]    ostat_reg,  ostat_next;

    bol_mem_req_t          mem_req;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic             in_xfer;
    logic             out_xfer;
    logic             out_free;
    logic [CNT_W-1:0] pos_ext;
    logic             issue;

    bol_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Handshake qualifiers.
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign pos_ext  = {{(CNT_W - POS_W){1'b0}}, pos_reg};

    // Command sequencer. Each entry is read before any write of the same
    // command touches it, so no forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        lim_next       = lim_reg;
        base_next      = base_reg;
        pend_next      = 1'b0;
        dec_next       = dec_reg;
        hit_next       = hit_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        paddr_next     = paddr_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        dout_next      = dout_reg;
        fpos_next      = fpos_reg;
        ecnt_next      = ecnt_reg;
        ostat_next     = ostat_reg;
        issue          = 1'b0;
        mem_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = operation;
                    pos_next   = position;
                    val_next   = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                data_next   = '0;
                found_next  = '0;
                status_next = ST_OK;
                hit_next    = 1'b0;
                state_next  = S_DONE;
                unique case (op_reg)
                    OP_APPEND, OP_INSERT:
                    begin
                        base_next = (op_reg == OP_APPEND) ? count_reg : pos_ext;
                        ptr_next  = count_reg;
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (op_reg == OP_INSERT && pos_ext > count_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_SHUP;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if ((op_reg == OP_REMOVE || op_reg == OP_READ)
                                 && pos_ext >= count_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            unique case (op_reg)
                                OP_POP_FRONT: base_next = '0;
                                OP_POP_BACK:  base_next = count_reg - CNT_W'(1);
                                default:      base_next = pos_ext;
                            endcase
                            ptr_next   = base_next;
                            lim_next   = (op_reg == OP_READ) ?
                                         base_next + CNT_W'(1) : count_reg;
                            dec_next   = (op_reg != OP_READ);
                            state_next = S_SHDN;
                        end
                    end
                    OP_FIND:
                    begin
                        ptr_next   = '0;
                        found_next = count_reg;
                        state_next = S_FIND;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Walk upward: the entry at the base is the result, the rest
            // move down one place.
            S_SHDN:
            begin
                issue = (ptr_reg < lim_reg);
                if (issue)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                pend_next  = issue;
                paddr_next = ptr_reg[IDX_W-1:0];
                if (pend_reg)
                begin
                    if (paddr_reg == base_reg[IDX_W-1:0])
                    begin
                        data_next = mem_rdata;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = paddr_reg - IDX_W'(1);
                        mem_req.wdata = mem_rdata;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    if (dec_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            // Walk downward moving entries up one place, then write the
            // new value into the opened slot.
            S_SHUP:
            begin
                issue = (ptr_reg > base_reg);
                if (issue)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    ptr_next      = ptr_reg - CNT_W'(1);
                end
                pend_next  = issue;
                paddr_next = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = paddr_reg + IDX_W'(1);
                    mem_req.wdata = mem_rdata;
                end
                if (!issue && !pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = base_reg[IDX_W-1:0];
                    mem_req.wdata = val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = S_DONE;
                end
            end

            // Scan from the front; stop reading after the first match.
            S_FIND:
            begin
                issue = (ptr_reg < count_reg) && !hit_reg;
                if (issue)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                pend_next  = issue;
                paddr_next = ptr_reg[IDX_W-1:0];
                if (pend_reg && !hit_reg && mem_rdata == val_reg)
                begin
                    hit_next   = 1'b1;
                    found_next = {{(CNT_W - IDX_W){1'b0}}, paddr_reg};
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    dout_next      = data_reg;
                    fpos_next      = found_reg;
                    ecnt_next      = count_reg;
                    ostat_next     = status_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            lim_reg       <= '0;
            base_reg      <= '0;
            pend_reg      <= 1'b0;
            dec_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            lim_reg       <= lim_next;
            base_reg      <= base_next;
            pend_reg      <= pend_next;
            dec_reg       <= dec_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        paddr_reg  <= paddr_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
        fpos_reg   <= fpos_next;
        ecnt_reg   <= ecnt_next;
        ostat_reg  <= ostat_next;
    end

    assign out_valid      = out_valid_reg;
    assign data_out       = dout_reg;
    assign found_position = fpos_reg;
    assign entry_count    = ecnt_reg;
    assign status         = ostat_reg;

    // The list never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // The memory is written only while entries are being moved or placed.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == S_SHDN || state_reg == S_SHUP))
        else $error("memory write outside a shift");

    // An accepted command is decoded in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_EXEC)
        else $error("accepted command not decoded");

    // A full report goes with a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ostat_reg == ST_FULL) |-> ecnt_reg == CNT_W'(CAPACITY))
        else $error("full status with a list that is not full");

endmodule

// ===== design/bol_mem.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list entry memory
// Simple dual-port synchronous memory: one write and one registered read
// per cycle. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bol_mem
    import bol_pkg::*;
(
    input  logic                  clk,
    input  bol_mem_req_t          req,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem_arr [CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_arr[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem_arr[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
